// ===== src/lca_pkg.sv =====
package lca_pkg;

  localparam int ID_W      = 10;
  localparam int DEPTH_W   = 10;
  localparam int COUNT_W   = 11;
  localparam int LEN_W     = 11;
  localparam int CFG_W     = 11;
  localparam int REG_IDX_W = 1;
  localparam int STEP_W    = 2;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 10'd1023;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2
  } lca_op_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_NODE_COUNT = 1'b0,
    REG_ROOT_NODE  = 1'b1
  } lca_reg_e;

  typedef struct packed {
    logic [1:0]      operation;
    logic [ID_W-1:0] child_node;
    logic [ID_W-1:0] parent_node;
    logic [ID_W-1:0] first_node;
    logic [ID_W-1:0] second_node;
    logic [ID_W-1:0] probe_node;
  } lca_req_t;

  typedef struct packed {
    logic [ID_W-1:0]  ancestor_node;
    logic [LEN_W-1:0] path_length;
    logic             probe_on_path;
  } lca_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NORM,
    ST_LD_RD,
    ST_LD_WR,
    ST_BD_ROOT,
    ST_BD_RD1,
    ST_BD_RD2,
    ST_BD_WR,
    ST_Q_SETUP,
    ST_Q_DX,
    ST_Q_DY,
    ST_Q_DYW,
    ST_Q_LIFT,
    ST_Q_LIFTW,
    ST_Q_CMP,
    ST_Q_DESC_U,
    ST_Q_DESC_V,
    ST_Q_DESC_W,
    ST_Q_LAST,
    ST_Q_LASTW,
    ST_Q_DC,
    ST_Q_DCW,
    ST_Q_OUT
  } lca_state_e;

endpackage

// ===== src/lca_ram.sv =====
module lca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/lowest_common_ancestor_engine.sv =====
// Channel   Dir  Handshake             Payload
// request   in   req_valid/req_stall   lca_req_t  (operation and node ids)
// response  out  rsp_valid/rsp_stall   lca_rsp_t  (ancestor, length, probe flag)
// config    in   cfg_write             cfg_index, cfg_data
//
// A sequencer works one request at a time around two memories with registered reads.
// Every request first reduces its ids modulo MAX_NODES; a load then reads the parent
// depth and writes the child's entries, a build fills ancestor levels 1 to LEVELS-1 for
// ids below min(node_count, MAX_NODES), a query runs three searches (bound by the single
// ancestor-table read port) and then hands its result to the response register.
// Reset (rst, synchronous) sets state, rsp_valid and config (node_count to 1), not datapath or tables.
module lowest_common_ancestor_engine
  import lca_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  lca_req_t             req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output lca_rsp_t             rsp,
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int ANC_W     = $clog2(MAX_NODES + 1);
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int ANC_AW    = LVL_W + NODE_W;
  localparam int ANC_DEPTH = LEVELS * (2 ** NODE_W);

  localparam logic [ANC_W-1:0] NO_ANC   = ANC_W'(MAX_NODES);
  localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVELS - 1);

  // Reciprocal of MAX_NODES, scaled so that the quotient is exact for any id
  localparam int RCP_W  = 2 * ID_W;
  localparam int PROD_W = ID_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'(((64'd1 << RCP_W) + 64'(MAX_NODES) - 64'd1) / 64'(MAX_NODES));
  localparam logic [ID_W-1:0]  MOD_V = ID_W'(MAX_NODES);

  // Id modulo MAX_NODES: quotient by reciprocal multiply, then subtract back
  function automatic logic [ID_W-1:0] mod_nodes(logic [ID_W-1:0] x);
    logic [PROD_W-1:0] prod;
    logic [ID_W-1:0]   quo;
    logic [RCP_W-1:0]  back;
    prod = PROD_W'(x) * PROD_W'(RCP);
    quo  = prod[PROD_W-1:RCP_W];
    back = quo * MOD_V;
    if (MAX_NODES >= (2 ** ID_W)) begin
      return x;
    end
    return x - back[ID_W-1:0];
  endfunction

  // Configuration registers
  logic [COUNT_W-1:0] node_count;
  logic [ID_W-1:0]    root_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= COUNT_W'(1);
      root_cfg   <= '0;
    end else if (cfg_write) begin
      unique case (lca_reg_e'(cfg_index))
        REG_NODE_COUNT: node_count <= cfg_data[COUNT_W-1:0];
        REG_ROOT_NODE:  root_cfg   <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and working registers
  lca_state_e state, state_next;
  lca_op_e    op;

  logic [ID_W-1:0]    xr [4];   // child/u, parent/v, probe, root
  logic [STEP_W-1:0]  step;
  logic [LVL_W-1:0]   lvl;
  logic [ANC_W-1:0]   j;
  logic [ANC_W-1:0]   t_node;
  logic [ANC_W-1:0]   qx, qy, qc, pu;
  logic [DEPTH_W-1:0] dx, diff;
  logic [LEN_W-1:0]   dsum;
  logic [1:0]         pass;
  logic [LEN_W-1:0]   dist0, dist1, dist2;
  logic [ID_W-1:0]    anc_res;

  // Memory ports
  logic               anc_we;
  logic [ANC_AW-1:0]  anc_wa, anc_ra;
  logic [ANC_W-1:0]   anc_wd, anc_rd;
  logic               dep_we;
  logic [NODE_W-1:0]  dep_wa, dep_ra;
  logic [DEPTH_W-1:0] dep_wd, dep_rd;

  lca_ram #(.WIDTH(ANC_W), .DEPTH(ANC_DEPTH)) u_anc_ram (
    .clk     (clk),
    .wr_en   (anc_we),
    .wr_addr (anc_wa),
    .wr_data (anc_wd),
    .rd_addr (anc_ra),
    .rd_data (anc_rd)
  );

  lca_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_NODES)) u_dep_ram (
    .clk     (clk),
    .wr_en   (dep_we),
    .wr_addr (dep_wa),
    .wr_data (dep_wd),
    .rd_addr (dep_ra),
    .rd_data (dep_rd)
  );

  // Derived values
  logic [NODE_W-1:0]  root_n;
  logic [ANC_W-1:0]   root_a;
  logic [ANC_W-1:0]   n_lim;
  logic [DEPTH_W-1:0] ld_dp, ld_dnew;
  logic [DEPTH_W-1:0] dy_v, dc_v, lift_sh;
  logic [ANC_W-1:0]   pv, cn;
  logic [LEN_W-1:0]   dist_v;
  logic               rsp_free;

  assign root_n   = NODE_W'(xr[3]);
  assign root_a   = ANC_W'(root_n);
  assign rsp_free = !rsp_valid || !rsp_stall;

  always_comb begin
    if ({21'b0, node_count} >= 32'(MAX_NODES)) begin
      n_lim = ANC_W'(MAX_NODES);
    end else begin
      n_lim = ANC_W'(node_count);
    end
  end

  // Parent depth plus one, saturating; the root always reads as depth zero.
  assign ld_dp   = (NODE_W'(xr[1]) == root_n) ? '0 : dep_rd;
  assign ld_dnew = (ld_dp >= DEPTH_MAX) ? DEPTH_MAX : ld_dp + DEPTH_W'(1);

  assign dy_v    = (qy == root_a) ? '0 : dep_rd;
  assign dc_v    = (qc == root_a) ? '0 : dep_rd;
  assign lift_sh = diff >> lvl;
  assign pv      = (qy >= NO_ANC) ? NO_ANC : anc_rd;
  assign cn      = (qc >= NO_ANC) ? root_a : qc;
  // Negative distances (inconsistent depths) clamp to zero.
  assign dist_v  = (dsum >= {dc_v, 1'b0}) ? dsum - {dc_v, 1'b0} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory controls
  always_comb begin
    state_next = state;
    req_stall  = (state != ST_IDLE);
    anc_we     = 1'b0;
    anc_wa     = '0;
    anc_wd     = '0;
    anc_ra     = '0;
    dep_we     = 1'b0;
    dep_wa     = '0;
    dep_wd     = '0;
    dep_ra     = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (req.operation) inside
            OP_LOAD, OP_BUILD, OP_QUERY: state_next = ST_NORM;
            default: ;  // unused operation code: drop
          endcase
        end
      end
      ST_NORM: begin
        if (step == '0) begin
          unique case (op)
            OP_LOAD:  state_next = ST_LD_RD;
            OP_BUILD: state_next = ST_BD_ROOT;
            default:  state_next = ST_Q_SETUP;
          endcase
        end
      end
      ST_LD_RD: begin
        dep_ra = NODE_W'(xr[1]);
        if (NODE_W'(xr[0]) == root_n) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_LD_WR;
        end
      end
      ST_LD_WR: begin
        anc_we     = 1'b1;
        anc_wa     = {LVL_W'(0), NODE_W'(xr[0])};
        anc_wd     = ANC_W'(NODE_W'(xr[1]));
        dep_we     = 1'b1;
        dep_wa     = NODE_W'(xr[0]);
        dep_wd     = ld_dnew;
        state_next = ST_IDLE;
      end
      ST_BD_ROOT: begin
        anc_we     = 1'b1;
        anc_wa     = {LVL_W'(0), root_n};
        anc_wd     = NO_ANC;
        state_next = ST_BD_RD1;
      end
      ST_BD_RD1: begin
        anc_ra = {lvl - LVL_W'(1), NODE_W'(j)};
        if (j >= n_lim) begin
          if (lvl == LVL_LAST) begin
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_BD_RD2;
        end
      end
      ST_BD_RD2: begin
        anc_ra     = {lvl - LVL_W'(1), NODE_W'(anc_rd)};
        state_next = ST_BD_WR;
      end
      ST_BD_WR: begin
        anc_we     = 1'b1;
        anc_wa     = {lvl, NODE_W'(j)};
        anc_wd     = (t_node >= NO_ANC) ? NO_ANC : anc_rd;
        state_next = ST_BD_RD1;
      end
      ST_Q_SETUP: state_next = ST_Q_DX;
      ST_Q_DX: begin
        dep_ra     = NODE_W'(qx);
        state_next = ST_Q_DY;
      end
      ST_Q_DY: begin
        dep_ra     = NODE_W'(qy);
        state_next = ST_Q_DYW;
      end
      ST_Q_DYW: state_next = ST_Q_LIFT;
      ST_Q_LIFT: begin
        anc_ra = {lvl, NODE_W'(qx)};
        if (lift_sh[0] && (qx < NO_ANC)) begin
          state_next = ST_Q_LIFTW;
        end else if (lvl == LVL_LAST) begin
          state_next = ST_Q_CMP;
        end
      end
      ST_Q_LIFTW: begin
        state_next = (lvl == LVL_LAST) ? ST_Q_CMP : ST_Q_LIFT;
      end
      ST_Q_CMP: begin
        state_next = (qx == qy) ? ST_Q_DC : ST_Q_DESC_U;
      end
      ST_Q_DESC_U: begin
        anc_ra     = {lvl, NODE_W'(qx)};
        state_next = ST_Q_DESC_V;
      end
      ST_Q_DESC_V: begin
        anc_ra     = {lvl, NODE_W'(qy)};
        state_next = ST_Q_DESC_W;
      end
      ST_Q_DESC_W: begin
        state_next = (lvl == '0) ? ST_Q_LAST : ST_Q_DESC_U;
      end
      ST_Q_LAST: begin
        anc_ra     = {LVL_W'(0), NODE_W'(qx)};
        state_next = ST_Q_LASTW;
      end
      ST_Q_LASTW: state_next = ST_Q_DC;
      ST_Q_DC: begin
        dep_ra     = NODE_W'(cn);
        state_next = ST_Q_DCW;
      end
      ST_Q_DCW: begin
        state_next = (pass == 2'd2) ? ST_Q_OUT : ST_Q_SETUP;
      end
      ST_Q_OUT: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op    <= lca_op_e'(req.operation);
        step  <= STEP_W'(3);
        pass  <= '0;
        xr[3] <= root_cfg;
        if (req.operation == OP_QUERY) begin
          xr[0] <= req.first_node;
          xr[1] <= req.second_node;
        end else begin
          xr[0] <= req.child_node;
          xr[1] <= req.parent_node;
        end
        xr[2] <= req.probe_node;
      end
      ST_NORM: begin
        // Reduce one id a cycle modulo MAX_NODES
        xr[step] <= mod_nodes(xr[step]);
        step     <= step - STEP_W'(1);
      end
      ST_BD_ROOT: begin
        lvl <= LVL_W'(1);
        j   <= '0;
      end
      ST_BD_RD1: begin
        if (j >= n_lim) begin
          lvl <= lvl + LVL_W'(1);
          j   <= '0;
        end
      end
      ST_BD_RD2: t_node <= anc_rd;
      ST_BD_WR:  j <= j + ANC_W'(1);
      ST_Q_SETUP: begin
        case (pass)
          2'd0: begin
            qx <= ANC_W'(NODE_W'(xr[0]));
            qy <= ANC_W'(NODE_W'(xr[1]));
          end
          2'd1: begin
            qx <= ANC_W'(NODE_W'(xr[0]));
            qy <= ANC_W'(NODE_W'(xr[2]));
          end
          default: begin
            qx <= ANC_W'(NODE_W'(xr[2]));
            qy <= ANC_W'(NODE_W'(xr[1]));
          end
        endcase
      end
      ST_Q_DY: dx <= (qx == root_a) ? '0 : dep_rd;
      ST_Q_DYW: begin
        dsum <= {1'b0, dx} + {1'b0, dy_v};
        lvl  <= '0;
        // Keep the deeper endpoint in qx
        if (dx < dy_v) begin
          qx   <= qy;
          qy   <= qx;
          diff <= dy_v - dx;
        end else begin
          diff <= dx - dy_v;
        end
      end
      ST_Q_LIFT: begin
        if (!(lift_sh[0] && (qx < NO_ANC)) && (lvl != LVL_LAST)) begin
          lvl <= lvl + LVL_W'(1);
        end
      end
      ST_Q_LIFTW: begin
        qx <= anc_rd;
        if (lvl != LVL_LAST) begin
          lvl <= lvl + LVL_W'(1);
        end
      end
      ST_Q_CMP: begin
        qc  <= qx;
        lvl <= LVL_LAST;
      end
      ST_Q_DESC_V: pu <= (qx >= NO_ANC) ? NO_ANC : anc_rd;
      ST_Q_DESC_W: begin
        if (pu != pv) begin
          qx <= pu;
          qy <= pv;
        end
        if (lvl != '0) begin
          lvl <= lvl - LVL_W'(1);
        end
      end
      ST_Q_LASTW: qc <= (qx >= NO_ANC) ? NO_ANC : anc_rd;
      ST_Q_DC:    qc <= cn;
      ST_Q_DCW: begin
        case (pass)
          2'd0: begin
            dist0   <= dist_v;
            anc_res <= ID_W'(qc);
          end
          2'd1:    dist1 <= dist_v;
          default: dist2 <= dist_v;
        endcase
        pass <= pass + 2'd1;
      end
      default: ;
    endcase
  end

  // Response register: frees the sequencer while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_Q_OUT && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_Q_OUT && rsp_free) begin
      rsp.ancestor_node <= anc_res;
      rsp.path_length   <= dist0;
      rsp.probe_on_path <= (({1'b0, dist1} + {1'b0, dist2}) == {1'b0, dist0});
    end
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import lca_pkg::*;

  localparam int NODES      = 1024;
  localparam int TREE_LVLS  = 11;
  localparam int NO_PARENT  = NODES;
  localparam int CYCLE_CAP  = 3000000;
  localparam int ITEM_GOAL  = 1400;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  lca_req_t req;
  logic     rsp_valid;
  logic     rsp_stall;
  lca_rsp_t rsp;
  logic     cfg_write;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  lowest_common_ancestor_engine dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the tree state, tracked request by request.
  int lift_tbl [TREE_LVLS][NODES];
  int depth_tbl [NODES];
  int shadow_count;
  int shadow_root;

  lca_rsp_t pending_answers[$];
  int       fails;
  int       sent_items;
  int       cycle_count;
  int       stall_left;
  bit       quiet_mode;   // no idling on either side while set

  // Clock: period 4.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int depth_at(int x);
    if (x >= NODES || x == shadow_root) return 0;
    return depth_tbl[x];
  endfunction

  function automatic int jump(int lvl, int x);
    if (x >= NODES) return NO_PARENT;
    return lift_tbl[lvl][x];
  endfunction

  function automatic int meet_point(int u, int v);
    int du, dv, gap, t, pu, pv;
    du = depth_at(u);
    dv = depth_at(v);
    if (du < dv) begin
      t = u; u = v; v = t;
      t = du; du = dv; dv = t;
    end
    gap = du - dv;
    for (int i = 0; i < TREE_LVLS; i++)
      if ((gap >> i) & 1) u = jump(i, u);
    if (u == v) return u;
    for (int i = TREE_LVLS - 1; i >= 0; i--) begin
      pu = jump(i, u);
      pv = jump(i, v);
      if (pu != pv) begin
        u = pu;
        v = pv;
      end
    end
    return jump(0, u);
  endfunction

  // Edge count between u and v; the meeting node comes back through c.
  function automatic int hop_count(int u, int v, output int c);
    int r;
    c = meet_point(u, v);
    if (c >= NODES) c = shadow_root;
    r = depth_at(u) + depth_at(v) - 2 * depth_at(c);
    return (r < 0) ? 0 : r;
  endfunction

  // Advance the shadow state by one request; returns 1 when an answer is due.
  function automatic bit apply_request(lca_req_t r, output lca_rsp_t ans);
    int c, p, d, lim, duv, dua, dav, meet, junk;
    ans = '0;
    case (r.operation)
      OP_LOAD: begin
        c = r.child_node;
        p = r.parent_node;
        if (c == shadow_root) return 0;
        d = depth_at(p);
        d = (d >= DEPTH_MAX) ? DEPTH_MAX : d + 1;
        lift_tbl[0][c] = p;
        depth_tbl[c]   = d;
        return 0;
      end
      OP_BUILD: begin
        lim = (shadow_count < NODES) ? shadow_count : NODES;
        lift_tbl[0][shadow_root] = NO_PARENT;
        for (int i = 1; i < TREE_LVLS; i++)
          for (int j = 0; j < lim; j++)
            lift_tbl[i][j] = jump(i - 1, lift_tbl[i - 1][j]);
        return 0;
      end
      OP_QUERY: begin
        duv = hop_count(r.first_node, r.second_node, meet);
        dua = hop_count(r.first_node, r.probe_node, junk);
        dav = hop_count(r.probe_node, r.second_node, junk);
        ans.ancestor_node = meet[ID_W-1:0];
        ans.path_length   = duv[LEN_W-1:0];
        ans.probe_on_path = (dua + dav == duv);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Response side: random stalls, compare against the oldest expected answer
  // ---------------------------------------------------------------------------
  task automatic report(string what, int got, int want);
    $display("MISMATCH %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
    fails++;
  endtask

  function automatic int idle_len();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Open, then hold the stall for a random gap; a gap of zero keeps it open.
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      rsp_stall  <= 1'b0;
      stall_left <= idle_len();
    end
  end

  always @(posedge clk) begin
    lca_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_answers.size() == 0) begin
        report("extra answer", 1, 0);
      end else begin
        want = pending_answers.pop_front();
        if (rsp.ancestor_node !== want.ancestor_node)
          report("ancestor_node", rsp.ancestor_node, want.ancestor_node);
        if (rsp.path_length !== want.path_length)
          report("path_length", rsp.path_length, want.path_length);
        if (rsp.probe_on_path !== want.probe_on_path)
          report("probe_on_path", rsp.probe_on_path, want.probe_on_path);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Present one request after a random gap and hold it until accepted.
  // Called and returns at a falling edge. A typed answer overrides the shadow's.
  task automatic send_req(lca_req_t r, bit typed = 0, lca_rsp_t typed_ans = '0);
    int gap;
    lca_rsp_t ans;
    gap = idle_len();
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid = 1'b1;
    req = r;
    do @(posedge clk); while (req_stall);
    if (apply_request(r, ans)) pending_answers = {pending_answers, typed ? typed_ans : ans};
    sent_items++;
    @(negedge clk);
  endtask

  function automatic lca_req_t make_req(logic [1:0] op, int c, int p, int u, int v, int a);
    lca_req_t r;
    r.operation   = op;
    r.child_node  = c[ID_W-1:0];
    r.parent_node = p[ID_W-1:0];
    r.first_node  = u[ID_W-1:0];
    r.second_node = v[ID_W-1:0];
    r.probe_node  = a[ID_W-1:0];
    return r;
  endfunction

  function automatic int rnd_id();
    return $urandom_range(0, NODES - 1);
  endfunction

  // Drain all answers, then let the block finish any trailing work.
  task automatic drain();
    req_valid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(lca_reg_e idx, int value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value[CFG_W-1:0];
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == REG_NODE_COUNT) shadow_count = value & 11'h7FF;
    else shadow_root = value & 10'h3FF;
  endtask

  task automatic setup_tree(int n, int r);
    write_reg(REG_NODE_COUNT, n);
    // bit 10 of the root write is dropped by the block; toggle it anyway
    write_reg(REG_ROOT_NODE, r | ($urandom_range(0, 1) << 10));
  endtask

  function automatic lca_req_t query_of(int loaded[$]);
    return make_req(OP_QUERY, rnd_id(), rnd_id(),
                    loaded[$urandom_range(0, loaded.size() - 1)],
                    loaded[$urandom_range(0, loaded.size() - 1)],
                    loaded[$urandom_range(0, loaded.size() - 1)]);
  endfunction

  // One random tree: every node below n but the root is loaded parent-first, then
  // built, then queried. Some noise and inconsistent reloads go in before the build.
  task automatic random_phase(int phase_no);
    int n, r, p, queries;
    int order[$];
    int loaded[$];
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
    r = $urandom_range(0, n - 1);
    quiet_mode = ($urandom_range(0, 3) == 0);
    setup_tree(n, r);
    for (int j = 0; j < n; j++) if (j != r) order = {order, j};
    order.shuffle();
    loaded = {loaded, r};
    foreach (order[k]) begin
      if ($urandom_range(0, 19) == 0)
        send_req(make_req(OP_IGNORED, rnd_id(), rnd_id(), rnd_id(), rnd_id(), rnd_id()));
      if ($urandom_range(0, 29) == 0)
        send_req(make_req(OP_LOAD, r, rnd_id(), rnd_id(), rnd_id(), rnd_id()));
      // favor the newest node so that deep chains appear
      p = ($urandom_range(0, 1) == 0) ? loaded[$] : loaded[$urandom_range(0, loaded.size() - 1)];
      send_req(make_req(OP_LOAD, order[k], p, rnd_id(), rnd_id(), rnd_id()));
      loaded = {loaded, order[k]};
    end
    if (n > 1 && $urandom_range(0, 4) == 0)
      repeat (2)
        send_req(make_req(OP_LOAD, loaded[$urandom_range(0, loaded.size() - 1)],
                          loaded[$urandom_range(0, loaded.size() - 1)],
                          rnd_id(), rnd_id(), rnd_id()));
    send_req(make_req(OP_BUILD, rnd_id(), rnd_id(), rnd_id(), rnd_id(), rnd_id()));
    queries = $urandom_range(10, 40);
    for (int q = 0; q < queries; q++) begin
      // hold off the sender until everything in flight has answered
      if (phase_no % 5 == 1 && q == queries / 2) begin
        req_valid = 1'b0;
        while (pending_answers.size() != 0) @(negedge clk);
      end
      send_req(query_of(loaded));
    end
    drain();
  endtask

  typedef struct {
    lca_req_t item;
    bit       typed;
    lca_rsp_t answer;
  } step_row_t;

  initial begin
    step_row_t steps[$];
    int loaded[$];

    fails = 0;
    sent_items = 0;
    cycle_count = 0;
    quiet_mode = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_NODE_COUNT;
    cfg_data = '0;
    shadow_count = 1;
    shadow_root = 0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // Directed: small tree rooted at 3 with 0 under it and 1, 2 under 0.
    setup_tree(4, 3);
    steps = '{
      '{make_req(OP_LOAD, 0, 3, 1023, 1023, 1023), 0, '0},
      '{make_req(OP_LOAD, 1, 0, 0, 0, 0), 0, '0},
      '{make_req(OP_LOAD, 2, 0, 1023, 0, 1023), 0, '0},
      // root loaded as a child: dropped
      '{make_req(OP_LOAD, 3, 1, 0, 1023, 0), 0, '0},
      '{make_req(OP_IGNORED, 1023, 1023, 1023, 1023, 1023), 0, '0},
      '{make_req(OP_BUILD, 0, 0, 0, 0, 0), 0, '0},
      '{make_req(OP_QUERY, 1023, 1023, 3, 3, 3), 1, '{10'd3, 11'd0, 1'b1}},
      '{make_req(OP_QUERY, 0, 0, 1, 2, 0), 1, '{10'd0, 11'd2, 1'b1}},
      '{make_req(OP_QUERY, 0, 0, 1, 2, 3), 1, '{10'd0, 11'd2, 1'b0}},
      '{make_req(OP_QUERY, 0, 0, 1, 3, 2), 1, '{10'd3, 11'd2, 1'b0}},
      '{make_req(OP_QUERY, 0, 0, 2, 1, 1), 0, '0},
      '{make_req(OP_QUERY, 0, 0, 0, 0, 2), 0, '0}
    };
    foreach (steps[k]) send_req(steps[k].item, steps[k].typed, steps[k].answer);
    drain();

    // Single-node tree: smallest node_count.
    setup_tree(1, 0);
    send_req(make_req(OP_BUILD, 1023, 1023, 1023, 1023, 1023));
    send_req(make_req(OP_QUERY, 0, 0, 0, 0, 0), 1, '{10'd0, 11'd0, 1'b1});
    drain();

    // Full-size chain rooted at the top id; the depth then saturates on a reload.
    setup_tree(NODES, NODES - 1);
    loaded = {loaded, NODES - 1};
    for (int j = 0; j < NODES - 1; j++) begin
      send_req(make_req(OP_LOAD, j, (j == 0) ? NODES - 1 : j - 1, rnd_id(), rnd_id(), rnd_id()));
      loaded = {loaded, j};
    end
    send_req(make_req(OP_BUILD, 0, 0, 0, 0, 0));
    send_req(make_req(OP_QUERY, 0, 0, 1022, NODES - 1, 511));
    send_req(make_req(OP_QUERY, 0, 0, 1022, 1022, 0));
    repeat (8) send_req(query_of(loaded));
    send_req(make_req(OP_LOAD, 5, 1022, 0, 0, 0));
    send_req(make_req(OP_BUILD, 0, 0, 0, 0, 0));
    repeat (10) send_req(query_of(loaded));
    drain();

    // Random trees until enough requests have gone out.
    for (int ph = 0; sent_items < ITEM_GOAL; ph++) random_phase(ph);

    quiet_mode = 1'b0;
    req_valid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
